@@ rtl/tscd_pkg.sv @@
// shared types and constants for the touch stuck calibration detector
// no dependencies

package tscd_pkg;

    localparam int WINDOW_DEF   = 36;
    localparam int POS_W        = 10;
    localparam int PRS_W        = 12;
    localparam int MIN_W        = 6;
    localparam int FILL_W       = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRS_SPAN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_SPAN    = 2'd2;

    localparam logic [MIN_W-1:0] MIN_SAMPLES_RST = 6'd22;
    localparam logic [PRS_W-1:0] PRS_SPAN_RST    = 12'd110;
    localparam logic [POS_W-1:0] POS_SPAN_RST    = 10'd14;

    typedef struct packed {
        logic             v;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [PRS_W-1:0] z;
    } cell_t;

    typedef struct packed {
        logic load;
        logic clear;
    } cell_ctl_t;

endpackage

@@ rtl/tscd_cell.sv @@
// one window cell: holds a sample and its valid flag, loads from its neighbor
// depends on tscd_pkg

module tscd_cell
    import tscd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl,
    input  cell_t     d_in,
    output cell_t     d_out
);

    logic             v_reg;
    logic [POS_W-1:0] x_reg;
    logic [POS_W-1:0] y_reg;
    logic [PRS_W-1:0] z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (ctl.clear) begin
            v_reg <= 1'b0;
        end else if (ctl.load) begin
            v_reg <= d_in.v;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            x_reg <= d_in.x;
            y_reg <= d_in.y;
            z_reg <= d_in.z;
        end
    end

    assign d_out = '{v: v_reg, x: x_reg, y: y_reg, z: z_reg};

endmodule

@@ rtl/tscd_span.sv @@
// min/max tracker over the rotating window and the stuck decision
// depends on tscd_pkg

module tscd_span
    import tscd_pkg::*;
(
    input  logic             aclk,
    input  logic             init,
    input  cell_t            init_smp,
    input  logic             en,
    input  cell_t            smp,
    input  logic [PRS_W-1:0] prs_span_min,
    input  logic [POS_W-1:0] pos_span_max,
    output logic             hit
);

    logic [POS_W-1:0] xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    logic [PRS_W-1:0] zmin_reg, zmax_reg;
    logic [POS_W-1:0] xspan, yspan;
    logic [PRS_W-1:0] zspan;

    always_ff @(posedge aclk) begin
        if (init) begin
            xmin_reg <= init_smp.x;
            xmax_reg <= init_smp.x;
            ymin_reg <= init_smp.y;
            ymax_reg <= init_smp.y;
            zmin_reg <= init_smp.z;
            zmax_reg <= init_smp.z;
        end else if (en && smp.v) begin
            if (smp.x < xmin_reg) xmin_reg <= smp.x;
            if (smp.x > xmax_reg) xmax_reg <= smp.x;
            if (smp.y < ymin_reg) ymin_reg <= smp.y;
            if (smp.y > ymax_reg) ymax_reg <= smp.y;
            if (smp.z < zmin_reg) zmin_reg <= smp.z;
            if (smp.z > zmax_reg) zmax_reg <= smp.z;
        end
    end

    assign xspan = xmax_reg - xmin_reg;
    assign yspan = ymax_reg - ymin_reg;
    assign zspan = zmax_reg - zmin_reg;
    assign hit   = (zspan >= prs_span_min) && (xspan <= pos_span_max)
                   && (yspan <= pos_span_max);

endmodule

@@ rtl/touch_stuck_calibration_detector.sv @@
// top level: sample window as a ring of cells, span tracker and control
// depends on tscd_pkg, tscd_cell, tscd_span
//
//   port group   dir   content
//   s_axis       in    tuser {cal_valid, contact}, tdata {pressure, pos_y, pos_x}
//   m_axis       out   tuser {stuck}, tdata {fill}
//   cfg          in    write enable, register index, write data
//
// a no-contact transfer or a sample without a check writes its result straight into the result register
// a checked sample passes through the scan and decide states: the ring rotates once past the tracker
// reset clears the window, the count and the registers to their defaults
// one result register; input is held off while it is full and not taken

module touch_stuck_calibration_detector
    import tscd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // pos_x, pos_y, pressure
    input  logic [1:0]            s_tuser,   // contact, cal_valid
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // fill, zero pad
    output logic [0:0]            m_tuser,   // stuck
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SCN_W = $clog2(WINDOW);
    localparam int CMP_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DECIDE} state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SCN_W-1:0] scan_reg, scan_next;
    logic [MIN_W-1:0] min_samples_reg;
    logic [PRS_W-1:0] prs_span_reg;
    logic [POS_W-1:0] pos_span_reg;
    logic             m_valid_reg, m_valid_next;
    logic             m_stuck_reg, m_stuck_next;
    logic [FILL_W-1:0] m_fill_reg, m_fill_next;

    cell_t     chain [WINDOW];
    cell_t     feed;
    cell_t     new_smp;
    cell_ctl_t ctl;
    logic      s_xfer, out_free, hit, check;
    logic      span_init, span_en;
    logic [CNT_W-1:0] cnt_push;
    logic [CMP_W-1:0] cnt_cmp, cnt_ext;

    assign new_smp  = '{v: 1'b1, x: s_tdata[9:0], y: s_tdata[19:10], z: s_tdata[31:20]};
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_xfer   = s_tvalid && s_tready;

    assign cnt_push = (count_reg == CNT_W'(WINDOW)) ? count_reg : count_reg + 1'b1;
    assign cnt_cmp  = CMP_W'(cnt_push);
    assign check    = s_tuser[1] && (cnt_cmp >= CMP_W'(min_samples_reg));
    assign cnt_ext  = CMP_W'(count_reg);

    assign feed = (state_reg == ST_IDLE) ? new_smp : chain[WINDOW-1];

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++) begin : g_cell
            tscd_cell u_cell (
                .aclk   (aclk),
                .aresetn(aresetn),
                .ctl    (ctl),
                .d_in   ((gi == 0) ? feed : chain[(gi == 0) ? 0 : gi - 1]),
                .d_out  (chain[gi])
            );
        end
    endgenerate

    tscd_span u_span (
        .aclk        (aclk),
        .init        (span_init),
        .init_smp    (new_smp),
        .en          (span_en),
        .smp         (chain[WINDOW-1]),
        .prs_span_min(prs_span_reg),
        .pos_span_max(pos_span_reg),
        .hit         (hit)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_stuck_next = m_stuck_reg;
        m_fill_next  = m_fill_reg;
        ctl          = '{load: 1'b0, clear: 1'b0};
        span_init    = 1'b0;
        span_en      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (!s_tuser[0]) begin
                        ctl.clear    = 1'b1;
                        count_next   = '0;
                        m_valid_next = 1'b1;
                        m_stuck_next = 1'b0;
                        m_fill_next  = '0;
                    end else begin
                        ctl.load   = 1'b1;
                        count_next = cnt_push;
                        if (check) begin
                            span_init  = 1'b1;
                            scan_next  = SCN_W'(WINDOW - 1);
                            state_next = ST_SCAN;
                        end else begin
                            m_valid_next = 1'b1;
                            m_stuck_next = 1'b0;
                            m_fill_next  = cnt_cmp[FILL_W-1:0];
                        end
                    end
                end
            end
            ST_SCAN: begin
                ctl.load = 1'b1;
                span_en  = 1'b1;
                scan_next = scan_reg - 1'b1;
                if (scan_reg == '0) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_stuck_next = hit;
                    m_fill_next  = hit ? '0 : cnt_ext[FILL_W-1:0];
                    if (hit) begin
                        ctl.clear  = 1'b1;
                        count_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            scan_reg    <= '0;
            m_valid_reg <= 1'b0;
            m_stuck_reg <= 1'b0;
            m_fill_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            scan_reg    <= scan_next;
            m_valid_reg <= m_valid_next;
            m_stuck_reg <= m_stuck_next;
            m_fill_reg  <= m_fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_samples_reg <= MIN_SAMPLES_RST;
            prs_span_reg    <= PRS_SPAN_RST;
            pos_span_reg    <= POS_SPAN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MIN_SAMPLES: min_samples_reg <= cfg_wdata[MIN_W-1:0];
                REG_PRS_SPAN:    prs_span_reg    <= cfg_wdata[PRS_W-1:0];
                REG_POS_SPAN:    pos_span_reg    <= cfg_wdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {2'b00, m_fill_reg};
    assign m_tuser[0] = m_stuck_reg;

endmodule

@@ dv/touch_stuck_calibration_detector_tb.sv @@
// self-checking testbench for touch_stuck_calibration_detector: directed, random and stall tests
// keeps its own window model to predict stuck and fill for each sample transfer
// depends on tscd_pkg and the detector rtl only
`timescale 1ns / 100ps

module touch_stuck_calibration_detector_tb;
    import tscd_pkg::*;

    localparam int WIN = WINDOW_DEF;
    localparam int DRAIN_CYCLES = WIN + 6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        bit             stuck;
        bit [FILL_W-1:0] fill;
    } verdict_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // window model and register copies
    bit [POS_W-1:0] ring_x [WIN];
    bit [POS_W-1:0] ring_y [WIN];
    bit [PRS_W-1:0] ring_z [WIN];
    int unsigned    held = 0;
    int unsigned    oldest = 0;
    bit [MIN_W-1:0] cur_min_samples = MIN_SAMPLES_RST;
    bit [PRS_W-1:0] cur_prs_span = PRS_SPAN_RST;
    bit [POS_W-1:0] cur_pos_span = POS_SPAN_RST;

    verdict_t verdict_q [$];

    int  fail_count = 0;
    int  samples_sent = 0;
    int  results_seen = 0;
    int  stuck_seen = 0;
    int  reg_writes = 0;
    int  burst_left = 0;
    bit  tx_busy = 1'b1;
    bit  rx_busy = 1'b1;
    int  hold_len = 0;

    touch_stuck_calibration_detector i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // pos_x, pos_y, pressure
        .s_tuser   (s_tuser),    // contact, cal_valid
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // fill, zero pad
        .m_tuser   (m_tuser),    // stuck
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic void track_sample(input bit contact, input bit [POS_W-1:0] x,
                                         input bit [POS_W-1:0] y, input bit [PRS_W-1:0] z,
                                         input bit cal);
        verdict_t v;
        int unsigned slot;
        int unsigned k;
        int xmin, xmax, ymin, ymax, zmin, zmax;
        v.stuck = 1'b0;
        if (!contact) begin
            held = 0;
            oldest = 0;
        end else begin
            if (held < WIN) begin
                slot = (oldest + held) % WIN;
                held++;
            end else begin
                slot = oldest;
                oldest = (oldest + 1) % WIN;
            end
            ring_x[slot] = x;
            ring_y[slot] = y;
            ring_z[slot] = z;
            if (held >= cur_min_samples && cal) begin
                xmin = x; xmax = x; ymin = y; ymax = y; zmin = z; zmax = z;
                for (int i = 0; i < held; i++) begin
                    k = (oldest + i) % WIN;
                    if (ring_x[k] < xmin) xmin = ring_x[k];
                    if (ring_x[k] > xmax) xmax = ring_x[k];
                    if (ring_y[k] < ymin) ymin = ring_y[k];
                    if (ring_y[k] > ymax) ymax = ring_y[k];
                    if (ring_z[k] < zmin) zmin = ring_z[k];
                    if (ring_z[k] > zmax) zmax = ring_z[k];
                end
                if ((zmax - zmin) >= cur_prs_span && (xmax - xmin) <= cur_pos_span &&
                    (ymax - ymin) <= cur_pos_span) begin
                    v.stuck = 1'b1;
                    held = 0;
                    oldest = 0;
                end
            end
        end
        v.fill = held[FILL_W-1:0];
        verdict_q.push_back(v);
    endfunction

    task automatic send_sample(input bit contact, input bit [POS_W-1:0] x,
                               input bit [POS_W-1:0] y, input bit [PRS_W-1:0] z,
                               input bit cal);
        int gap;
        if (tx_busy && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 45) : $urandom_range(1, 5);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tuser  <= {cal, contact};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_sample(contact, x, y, z, cal);
        samples_sent++;
        if (burst_left > 0) burst_left--;
    endtask

    // sender pauses until every expected result is back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MIN_SAMPLES: cur_min_samples = val[MIN_W-1:0];
            REG_PRS_SPAN:    cur_prs_span = val[PRS_W-1:0];
            REG_POS_SPAN:    cur_pos_span = val[POS_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // unused upper write bits are filled with noise
    task automatic set_thresholds(input bit [MIN_W-1:0] min_n, input bit [PRS_W-1:0] prs,
                                  input bit [POS_W-1:0] pos);
        drain();
        write_reg(REG_MIN_SAMPLES, {6'($urandom), min_n});
        write_reg(REG_PRS_SPAN, prs);
        write_reg(REG_POS_SPAN, {2'($urandom), pos});
    endtask

    function automatic bit [POS_W-1:0] jitter(input bit [POS_W-1:0] c, input int spread);
        int t;
        t = c + $urandom_range(0, spread);
        return (t > 1023) ? 10'd1023 : t[POS_W-1:0];
    endfunction

    // strokes of pinned or drifting touch with random pressure, plus noise
    task automatic random_strokes(input int n_items);
        int left, run, spread, r;
        bit [POS_W-1:0] cx, cy, x, y;
        bit [PRS_W-1:0] z;
        left = n_items;
        while (left > 0) begin
            run = $urandom_range(1, 60);
            cx = POS_W'($urandom);
            cy = POS_W'($urandom);
            if ($urandom_range(0, 3) == 0) spread = $urandom_range(0, 1023);
            else spread = $urandom_range(0, cur_pos_span + 1);
            for (int k = 0; k < run && left > 0; k++) begin
                r = $urandom_range(0, 99);
                x = jitter(cx, spread);
                y = jitter(cy, spread);
                case ($urandom_range(0, 7))
                    0: z = 12'd0;
                    1: z = 12'd4095;
                    default: z = PRS_W'($urandom);
                endcase
                if (r < 3)
                    send_sample(1'b0, POS_W'($urandom), POS_W'($urandom), PRS_W'($urandom),
                                1'($urandom));
                else if (r < 8)
                    send_sample(1'b1, POS_W'($urandom), POS_W'($urandom), z, 1'b1);
                else
                    send_sample(1'b1, x, y, z, r >= 16);
                left--;
            end
        end
    endtask

    task automatic test_directed();
        // reset thresholds, window still short
        send_sample(1'b0, 10'd1023, 10'd1023, 12'd4095, 1'b1);
        send_sample(1'b1, 10'd0, 10'd0, 12'd0, 1'b0);
        send_sample(1'b1, 10'd1023, 10'd1023, 12'd4095, 1'b1);
        send_sample(1'b1, 10'd511, 10'd512, 12'd2048, 1'b1);
        // zero minimum: every contact sample checked, widest limits
        set_thresholds(6'd0, 12'd0, 10'd1023);
        send_sample(1'b1, 10'd0, 10'd0, 12'd0, 1'b1);
        send_sample(1'b1, 10'd1023, 10'd0, 12'd4095, 1'b1);
        // tightest limits: pinned position, full pressure swing
        set_thresholds(6'd3, 12'd4095, 10'd0);
        write_reg(REG_UNUSED, 12'hfff);
        send_sample(1'b1, 10'd512, 10'd512, 12'd0, 1'b1);
        send_sample(1'b1, 10'd512, 10'd512, 12'd4095, 1'b1);
        send_sample(1'b1, 10'd512, 10'd512, 12'd100, 1'b1);
        send_sample(1'b1, 10'd512, 10'd512, 12'd0, 1'b1);
        send_sample(1'b1, 10'd512, 10'd512, 12'd4095, 1'b1);
        send_sample(1'b1, 10'd513, 10'd512, 12'd7, 1'b1);
        send_sample(1'b1, 10'd513, 10'd512, 12'd7, 1'b0);
        send_sample(1'b0, 10'd0, 10'd0, 12'd0, 1'b0);
        // minimum above the window size
        set_thresholds(6'd40, 12'd0, 10'd1023);
        send_sample(1'b1, 10'd5, 10'd5, 12'd5, 1'b1);
        send_sample(1'b1, 10'd5, 10'd5, 12'd5, 1'b1);
        send_sample(1'b1, 10'd5, 10'd5, 12'd5, 1'b1);
    endtask

    task automatic test_random_phases();
        set_thresholds(6'd1, 12'd0, 10'd1023);
        random_strokes(100);
        set_thresholds(6'd36, 12'd4095, 10'd0);
        random_strokes(100);
        set_thresholds(6'd63, PRS_W'($urandom), POS_W'($urandom));
        random_strokes(80);
        // no idling on either side
        set_thresholds(MIN_SAMPLES_RST, PRS_SPAN_RST, POS_SPAN_RST);
        tx_busy = 1'b0;
        rx_busy = 1'b0;
        random_strokes(120);
        tx_busy = 1'b1;
        rx_busy = 1'b1;
        repeat (2) begin
            set_thresholds(MIN_W'($urandom_range(1, 36)), PRS_W'($urandom_range(0, 600)),
                           POS_W'($urandom_range(0, 40)));
            random_strokes(100);
        end
        set_thresholds(6'd0, PRS_W'($urandom_range(0, 4095)), POS_W'($urandom_range(0, 1023)));
        random_strokes(60);
    endtask

    // result side held off while the sender keeps offering
    task automatic test_backpressure();
        set_thresholds(6'd4, 12'd50, 10'd3);
        tx_busy = 1'b0;
        hold_len = 400;
        random_strokes(40);
        drain();
        tx_busy = 1'b1;
        random_strokes(20);
    endtask

    always @(negedge aclk) begin : rx_pattern
        int r;
        int stall_left;
        if (hold_len > 0) begin
            m_tready <= 1'b0;
            hold_len = hold_len - 1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (!rx_busy) begin
            m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                stall_left = $urandom_range(5, 50);
                m_tready <= 1'b0;
            end else begin
                m_tready <= (r >= 30);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
                $error("result transfer with no sample pending: stuck %0d fill %0d",
                       m_tuser[0], m_tdata[FILL_W-1:0]);
                fail_count++;
            end else begin
                want = verdict_q.pop_front();
                if (want.stuck) stuck_seen++;
                if (m_tuser[0] !== want.stuck) begin
                    $error("stuck: expected %0d, actual %0d", want.stuck, m_tuser[0]);
                    fail_count++;
                end
                if (m_tdata[FILL_W-1:0] !== want.fill) begin
                    $error("fill: expected %0d, actual %0d", want.fill, m_tdata[FILL_W-1:0]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_phases();
        test_backpressure();
        drain();
        $display("run covered %0d sample transfers and %0d result transfers, %0d stuck",
                 samples_sent, results_seen, stuck_seen);
        $display("thresholds changed over %0d register writes", reg_writes);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ touch_stuck_calibration_detector.f @@
rtl/tscd_pkg.sv
rtl/tscd_cell.sv
rtl/tscd_span.sv
rtl/touch_stuck_calibration_detector.sv
dv/touch_stuck_calibration_detector_tb.sv
